/* rtl/stereo_sad_block_match_core_macros.svh */
// Assertion macros for the stereo SAD block matcher.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef STEREO_SAD_BLOCK_MATCH_CORE_MACROS_SVH
`define STEREO_SAD_BLOCK_MATCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SBM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sbm assertion failed");
`define SBM_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sbm assertion failed");
`else
`define SBM_ASSERT_IMP(label, clk, rst_n, a, b)
`define SBM_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/sbm_pkg.sv */
// Shared types, codes and helpers of the stereo SAD block matcher.
// No dependencies.
package sbm_pkg;

    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } t_col;

    typedef struct packed {
        logic shift;
        logic rotate;
    } t_cell_ctl;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_SEARCH = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_NUM_DISP     = 2'd2,
        CFG_THRESHOLD    = 2'd3
    } t_cfg_idx;

    localparam logic [10:0] FW_RESET   = 11'd640;
    localparam logic [10:0] FH_RESET   = 11'd480;
    localparam logic [6:0]  ND_RESET   = 7'd64;
    localparam logic [11:0] THR_RESET  = 12'd2296;
    localparam logic [10:0] MAX_HEIGHT = 11'd1024;
    localparam logic [11:0] MARGIN     = 12'd6;
    localparam logic [11:0] BIG_COST   = 12'hFFF;

    function automatic logic [7:0] f_absdiff(input logic [7:0] a, input logic [7:0] b);
        f_absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/sbm_cell.sv */
// One right-image column cell of the disparity chain.
// Depends on sbm_pkg; shifts from its left neighbor or rotates from its right one.
module sbm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbm_pkg::t_cell_ctl i_ctl,
    input  sbm_pkg::t_col     i_shift_col,
    input  sbm_pkg::t_col     i_rot_col,
    output sbm_pkg::t_col     o_col
);
    import sbm_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctl.shift) begin
            r_col <= i_shift_col;
        end else if (i_ctl.rotate) begin
            r_col <= i_rot_col;
        end
    end

    assign o_col = r_col;
endmodule

/* rtl/sbm_line_store.sv */
// Two-line sample store: one write port, two registered read ports.
// No dependencies; plain memory.
module sbm_line_store #(
    parameter int AW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [15:0]   o_rdata_a,
    output logic [15:0]   o_rdata_b
);
    logic [15:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end
endmodule

/* rtl/stereo_sad_block_match_core.sv */
// Stereo SAD block matcher top level: position tracking, line store, window
// chain and best/second cost search. Depends on sbm_pkg, sbm_cell, sbm_line_store.
//
// One request carries a left/right pixel pair. A request that yields no result
// runs S_SHIFT and returns to S_IDLE; one whose centre is border or excluded
// runs S_SHIFT and S_FINISH. A searched centre runs S_SHIFT, S_SEARCH, S_DRAIN
// and S_FINISH; the search makes one full rotation of the MAX_DISP + 2 cell
// right-column chain past the 3x3 SAD unit, one disparity per cycle. A request
// with a result waits in S_FINISH while the previous result is still held on
// the output. After reset all 2 * MAX_WIDTH line store entries (MAX_WIDTH
// rounded up to a power of two) are cleared before the first request.
`include "stereo_sad_block_match_core_macros.svh"
module stereo_sad_block_match_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_DISP  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_left_pixel,
    input  logic [7:0]  i_right_pixel,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_disparity,
    output logic [9:0]  o_out_col,
    output logic [9:0]  o_out_row,
    output logic        o_frame_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import sbm_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int AW      = CW + 1;
    localparam int RW_COLS = MAX_DISP + 2;
    localparam int DW      = $clog2(RW_COLS);
    localparam logic [12:0] MAXW   = 13'(MAX_WIDTH);
    localparam logic [7:0]  MAXD   = 8'(MAX_DISP);
    localparam logic [DW-1:0] D_LAST = DW'(RW_COLS - 1);

    t_state r_state;
    logic [AW-1:0] r_clr;
    logic [10:0] r_fw, r_fh;
    logic [6:0]  r_nd;
    logic [11:0] r_thr;
    logic [CW-1:0] r_col, r_c;
    logic [9:0]  r_row, r_r;
    logic [7:0]  r_lp, r_rp;
    logic        r_last, r_elig;
    logic [DW-1:0] r_d, r_sad_d, r_bd;
    logic [11:0] r_sad, r_best, r_second;
    logic        r_sad_v;
    t_col        r_lw [3];
    logic        r_ov;
    logic [5:0]  r_disp;
    logic [9:0]  r_ocol, r_orow;
    logic        r_olast;

    // geometry
    logic [12:0] w_eff, h_eff;
    logic [7:0]  nd_eff;
    always_comb begin
        w_eff = (r_fw < 11'd3) ? 13'd3 : (({2'b0, r_fw} > MAXW) ? MAXW : {2'b0, r_fw});
        h_eff = (r_fh < 11'd3) ? 13'd3 :
                ((r_fh > MAX_HEIGHT) ? {2'b0, MAX_HEIGHT} : {2'b0, r_fh});
        nd_eff = ({1'b0, r_nd} > MAXD) ? MAXD : {1'b0, r_nd};
    end

    // position of the incoming request
    logic [CW-1:0] pos_c;
    logic [10:0]   pos_r;
    logic [CW:0]   c_inc;
    logic [10:0]   r_inc;
    logic [CW-1:0] nxt_col;
    logic [9:0]    nxt_row;
    always_comb begin
        pos_c = i_frame_start ? '0 : r_col;
        pos_r = i_frame_start ? 11'd0 : {1'b0, r_row};
        if (13'(pos_c) >= w_eff) begin
            pos_c = '0;
            pos_r = pos_r + 11'd1;
        end
        if (13'(pos_r) >= h_eff) begin
            pos_r = 11'd0;
        end
        c_inc   = {1'b0, pos_c} + 1'b1;
        r_inc   = pos_r + 11'd1;
        nxt_col = CW'(c_inc);
        nxt_row = pos_r[9:0];
        if (13'(c_inc) >= w_eff) begin
            nxt_col = '0;
            nxt_row = (13'(r_inc) >= h_eff) ? 10'd0 : r_inc[9:0];
        end
    end

    logic in_acc, out_acc;
    assign o_ready     = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign out_acc     = r_ov && i_ready;
    assign o_cfg_ready = 1'b1;

    // line store
    logic          ls_we;
    logic [AW-1:0] ls_waddr;
    logic [15:0]   ls_wdata, rd_old, rd_prev;
    assign ls_we    = (r_state == S_CLEAR) || (r_state == S_SHIFT);
    assign ls_waddr = (r_state == S_CLEAR) ? r_clr : {r_r[0], r_c};
    assign ls_wdata = (r_state == S_CLEAR) ? 16'd0 : {r_lp, r_rp};

    sbm_line_store #(.AW(AW)) u_line (
        .i_clk    (i_clk),
        .i_we     (ls_we),
        .i_waddr  (ls_waddr),
        .i_wdata  (ls_wdata),
        .i_raddr_a({pos_r[0], pos_c}),
        .i_raddr_b({~pos_r[0], pos_c}),
        .o_rdata_a(rd_old),
        .o_rdata_b(rd_prev)
    );

    // right column chain
    t_col      new_rcol, new_lcol;
    t_col      rcol [RW_COLS];
    t_cell_ctl cell_ctl;
    assign new_rcol = '{top: rd_old[7:0], mid: rd_prev[7:0], bot: r_rp};
    assign new_lcol = '{top: rd_old[15:8], mid: rd_prev[15:8], bot: r_lp};
    assign cell_ctl = '{shift: (r_state == S_SHIFT), rotate: (r_state == S_SEARCH)};

    for (genvar k = 0; k < RW_COLS; k++) begin : g_cell
        sbm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_shift_col((k == 0) ? new_rcol : rcol[(k == 0) ? 0 : k - 1]),
            .i_rot_col  (rcol[(k + 1) % RW_COLS]),
            .o_col      (rcol[k])
        );
    end

    // SAD of the left window against the three leading chain cells
    logic [11:0] sad_sum;
    always_comb begin
        sad_sum = '0;
        for (int k = 0; k < 3; k++) begin
            sad_sum = sad_sum + 12'(f_absdiff(r_lw[k].top, rcol[k].top))
                              + 12'(f_absdiff(r_lw[k].mid, rcol[k].mid))
                              + 12'(f_absdiff(r_lw[k].bot, rcol[k].bot));
        end
    end

    // decision for the centre
    logic [CW-1:0] cx;
    logic [9:0]    cy;
    logic          produced, elig, accept_best;
    assign cx       = r_c - 1'b1;
    assign cy       = r_r - 10'd1;
    assign produced = (r_r != 10'd0) && (r_c != '0);
    assign elig     = (nd_eff >= 8'd2) && (cy != 10'd0) && (13'(cx) > 13'(nd_eff));
    assign accept_best = r_elig && (r_best < r_thr) &&
                         ((r_second == r_best) || ((r_second - r_best) > MARGIN));

    t_state n_state;
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:   if (in_acc) n_state = S_SHIFT;
            S_SHIFT:  n_state = !produced ? S_IDLE : (elig ? S_SEARCH : S_FINISH);
            S_SEARCH: if (r_d == D_LAST) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: if (!r_ov || i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fw    <= FW_RESET;
            r_fh    <= FH_RESET;
            r_nd    <= ND_RESET;
            r_thr   <= THR_RESET;
            r_col   <= '0;
            r_row   <= '0;
            r_ov    <= 1'b0;
            r_sad_v <= 1'b0;
            for (int k = 0; k < 3; k++) r_lw[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FRAME_WIDTH:  r_fw  <= i_cfg_data[10:0];
                    CFG_FRAME_HEIGHT: r_fh  <= i_cfg_data[10:0];
                    CFG_NUM_DISP:     r_nd  <= i_cfg_data[6:0];
                    CFG_THRESHOLD:    r_thr <= i_cfg_data;
                    default:          r_thr <= r_thr;
                endcase
            end
            if (in_acc) begin
                r_col <= nxt_col;
                r_row <= nxt_row;
            end
            if (r_state == S_SHIFT) begin
                r_lw[0] <= new_lcol;
                r_lw[1] <= r_lw[0];
                r_lw[2] <= r_lw[1];
            end
            r_sad_v <= (r_state == S_SEARCH) && (8'(r_d) < nd_eff);
            if (out_acc) r_ov <= 1'b0;
            if ((r_state == S_FINISH) && (!r_ov || i_ready)) r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_c    <= pos_c;
            r_r    <= pos_r[9:0];
            r_lp   <= i_left_pixel;
            r_rp   <= i_right_pixel;
            r_last <= (13'(c_inc) == w_eff) && (13'(r_inc) == h_eff);
        end
        if (r_state == S_SHIFT) begin
            r_elig   <= elig;
            r_d      <= '0;
            r_best   <= BIG_COST;
            r_second <= BIG_COST;
            r_bd     <= '0;
        end
        if (r_state == S_SEARCH) begin
            r_d     <= r_d + 1'b1;
            r_sad   <= sad_sum;
            r_sad_d <= r_d;
        end
        if (r_sad_v) begin
            if (r_sad < r_best) begin
                r_second <= r_best;
                r_best   <= r_sad;
                r_bd     <= r_sad_d;
            end else if (r_sad < r_second) begin
                r_second <= r_sad;
            end
        end
        if ((r_state == S_FINISH) && (!r_ov || i_ready)) begin
            r_disp  <= accept_best ? 6'(r_bd) : 6'd0;
            r_ocol  <= 10'(cx);
            r_orow  <= cy;
            r_olast <= r_last;
        end
    end

    assign o_valid      = r_ov;
    assign o_disparity  = r_disp;
    assign o_out_col    = r_ocol;
    assign o_out_row    = r_orow;
    assign o_frame_last = r_olast;

    `SBM_ASSERT_IMP(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `SBM_ASSERT_IMP(a_search_bound, i_clk, i_rst_n, r_state == S_SEARCH, r_d <= D_LAST)
    `SBM_ASSERT_NXT(a_accept_shift, i_clk, i_rst_n, in_acc, r_state == S_SHIFT)
    `SBM_ASSERT_IMP(a_best_order, i_clk, i_rst_n, r_state == S_FINISH, r_best <= r_second)
endmodule
